// ===== src/cpe_pkg.sv =====
// Shared types and constants for the code point encoder.
// No dependencies; compile first.
package cpe_pkg;

   // Output format codes held in the format register.
   localparam logic [1:0] FMT_UTF8  = 2'd0;
   localparam logic [1:0] FMT_UTF16 = 2'd1;
   localparam logic [1:0] FMT_CESC  = 2'd2;

   // Queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified item: what the back end needs to emit its run.
   typedef struct packed {
      logic [31:0] code;
      logic [1:0]  fmt;
      logic [3:0]  count;   // units in the run, 1 to 10
      logic        err;     // no encoding: single error unit
   } job_type;

endpackage

// ===== src/cpe_channels.sv =====
// Valid/ready channel interfaces for the code point encoder.
// Depends on nothing; compiled after cpe_pkg.
interface cpe_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] code_point;

   modport source (output valid, output code_point, input ready);
   modport sink   (input valid, input code_point, output ready);
endinterface

interface cpe_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] unit;
   logic        last;
   logic        unrepresentable;

   modport source (output valid, output unit, output last, output unrepresentable,
                   input ready);
   modport sink   (input valid, input unit, input last, input unrepresentable,
                   output ready);
endinterface

// ===== src/cpe_front.sv =====
// Front end: takes code points and classifies them by run length.
// Depends on cpe_pkg and cpe_req_if.
module cpe_front (
   cpe_req_if.sink          req,
   input  logic [1:0]       fmt,
   output logic             push_valid,
   input  logic             push_ready,
   output cpe_pkg::job_type push_job
);
   import cpe_pkg::*;

   logic [31:0] v;

   assign v          = req.code_point;
   assign req.ready  = push_ready;
   assign push_valid = req.valid;

   always_comb begin
      push_job.code  = v;
      push_job.fmt   = fmt;
      push_job.count = 4'd1;
      push_job.err   = 1'b0;
      case (fmt)
         FMT_UTF8: begin
            if (v < 32'h0000_0080)      push_job.count = 4'd1;
            else if (v < 32'h0000_0800) push_job.count = 4'd2;
            else if (v < 32'h0001_0000) push_job.count = 4'd3;
            else if (v < 32'h0020_0000) push_job.count = 4'd4;
            else if (v < 32'h0400_0000) push_job.count = 4'd5;
            else if (v < 32'h8000_0000) push_job.count = 4'd6;
            else                        push_job.err   = 1'b1;
         end
         FMT_UTF16: begin
            if (v inside {[32'h0000_0000:32'h0000_D7FF], [32'h0000_E000:32'h0000_FFFF]})
               push_job.count = 4'd1;
            else if (v inside {[32'h0001_0000:32'h0010_FFFF]})
               push_job.count = 4'd2;
            else
               push_job.err = 1'b1;
         end
         FMT_CESC: begin
            push_job.count = (v < 32'h0001_0000) ? 4'd6 : 4'd10;
         end
         default: begin
            push_job.err = 1'b1;
         end
      endcase
   end

endmodule

// ===== src/cpe_queue.sv =====
// Short job queue between the front and back ends.
// Depends on cpe_pkg.
module cpe_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  cpe_pkg::job_type push_job,
   output logic             head_valid,
   input  logic             pop,
   output cpe_pkg::job_type head_job
);
   import cpe_pkg::*;

   job_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   fill_ff, fill_in;
   logic                do_push, do_pop;

   assign push_ready = (fill_ff != QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (fill_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) fill_in = fill_ff + 1'b1;
      else if (!do_push && do_pop) fill_in = fill_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== src/cpe_back.sv =====
// Back end: walks the head job one unit per cycle into a registered output, holding while rsp stalls.
// Depends on cpe_pkg and cpe_rsp_if.
module cpe_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  cpe_pkg::job_type head_job,
   output logic             pop,
   cpe_rsp_if.source        rsp
);
   import cpe_pkg::*;

   localparam logic [7:0] ASCII_BSLASH = 8'h5C;
   localparam logic [7:0] ASCII_LOW_U  = 8'h75;
   localparam logic [7:0] ASCII_UP_U   = 8'h55;

   logic [3:0]  index_ff, index_in;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] unit_ff;
   logic        last_ff, err_ff;

   logic        advance, emit, is_last;
   logic [3:0]  pos;        // units still to come after this one
   logic [31:0] v;
   logic [19:0] sur;        // code point less 0x10000
   logic [5:0]  sextet;
   logic [3:0]  nib;
   logic [7:0]  hex_char;
   logic [15:0] unit_val;

   assign v       = head_job.code;
   assign pos     = head_job.count - 4'd1 - index_ff;
   assign is_last = (pos == 4'd0);
   assign advance = !out_valid_ff || rsp.ready;
   assign emit    = head_valid && advance;
   assign pop     = emit && is_last;
   assign sur     = 20'(v - 32'h0001_0000);

   always_comb begin
      case (pos)
         4'd0:    sextet = v[5:0];
         4'd1:    sextet = v[11:6];
         4'd2:    sextet = v[17:12];
         4'd3:    sextet = v[23:18];
         4'd4:    sextet = v[29:24];
         default: sextet = 6'd0;
      endcase
      case (pos)
         4'd0:    nib = v[3:0];
         4'd1:    nib = v[7:4];
         4'd2:    nib = v[11:8];
         4'd3:    nib = v[15:12];
         4'd4:    nib = v[19:16];
         4'd5:    nib = v[23:20];
         4'd6:    nib = v[27:24];
         4'd7:    nib = v[31:28];
         default: nib = 4'd0;
      endcase
      hex_char = (nib < 4'd10) ? 8'h30 + {4'h0, nib} : 8'h37 + {4'h0, nib};
   end

   always_comb begin
      unit_val = 16'h0000;
      if (!head_job.err) begin
         case (head_job.fmt)
            FMT_UTF8: begin
               if (index_ff != 4'd0) begin
                  unit_val = {8'h00, 2'b10, sextet};
               end else begin
                  case (head_job.count)
                     4'd1:    unit_val = {8'h00, v[7:0]};
                     4'd2:    unit_val = {8'h00, 3'b110, v[10:6]};
                     4'd3:    unit_val = {8'h00, 4'b1110, v[15:12]};
                     4'd4:    unit_val = {8'h00, 5'b11110, v[20:18]};
                     4'd5:    unit_val = {8'h00, 6'b111110, v[25:24]};
                     4'd6:    unit_val = {8'h00, 7'b1111110, v[30]};
                     default: unit_val = 16'h0000;
                  endcase
               end
            end
            FMT_UTF16: begin
               if (head_job.count == 4'd1)   unit_val = v[15:0];
               else if (index_ff == 4'd0)    unit_val = {6'b110110, sur[19:10]};
               else                          unit_val = {6'b110111, sur[9:0]};
            end
            FMT_CESC: begin
               if (index_ff == 4'd0)
                  unit_val = {8'h00, ASCII_BSLASH};
               else if (index_ff == 4'd1)
                  unit_val = {8'h00, (head_job.count == 4'd6) ? ASCII_LOW_U : ASCII_UP_U};
               else
                  unit_val = {8'h00, hex_char};
            end
            default: unit_val = 16'h0000;
         endcase
      end
   end

   always_comb begin
      index_in     = index_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         index_in     = is_last ? 4'd0 : index_ff + 4'd1;
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         index_ff     <= 4'd0;
         out_valid_ff <= 1'b0;
      end else begin
         index_ff     <= index_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         unit_ff <= unit_val;
         last_ff <= is_last;
         err_ff  <= head_job.err;
      end
   end

   assign rsp.valid           = out_valid_ff;
   assign rsp.unit            = unit_ff;
   assign rsp.last            = last_ff;
   assign rsp.unrepresentable = err_ff;

endmodule

// ===== src/code_point_encoder_core.sv =====
// Code point encoder, top level: format register, front end, queue, back end.
// Depends on cpe_pkg, cpe_channels, cpe_front, cpe_queue, cpe_back.
//
// Usage:
//  - req carries one 32-bit code point per transfer (valid/ready).
//  - rsp carries one unit per transfer: a UTF-8 byte, a UTF-16 unit or an
//    ASCII escape character; last marks the final unit of a code point's run.
//  - A code point with no encoding in the selected format (or format 3)
//    gives a single transfer with unit 0, last 1, unrepresentable 1.
//  - csr_write_enable/csr_write_data load the 2-bit format register
//    (0 UTF-8, 1 UTF-16, 2 C escape); write it only while the block is idle.
//  - The first unit of a code point reaches rsp through the queue entry and
//    then the output register. Throughput: one rsp unit per cycle while rsp
//    is not stalled; a code point has 1-6 units in UTF-8, 1-2 in UTF-16 and
//    6 or 10 in escape. The back end's single output register sets that rate.
//  - A two-entry queue sits between front and back, so req keeps taking
//    code points while the back end works or rsp is stalled, until the queue
//    is full; when rsp stalls, the output register holds its unit meanwhile.
//  - Reset (synchronous, active high) empties queue and output and sets
//    the format register to UTF-8.
module code_point_encoder_core (
   input  logic       clock,
   input  logic       reset,
   cpe_req_if.sink    req,
   cpe_rsp_if.source  rsp,
   input  logic       csr_write_enable,
   input  logic [1:0] csr_write_data
);
   import cpe_pkg::*;

   logic [1:0] fmt_ff;

   // front -> queue
   logic    push_valid, push_ready;
   job_type push_job;

   // queue -> back
   logic    head_valid, pop;
   job_type head_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_UTF8;
      end else if (csr_write_enable) begin
         fmt_ff <= csr_write_data;
      end
   end

   // Classify each code point as it arrives: run length and error.
   cpe_front u_front (
      .req        (req),
      .fmt        (fmt_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   // Decouples intake from the unit-per-cycle emitter.
   cpe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .head_valid (head_valid),
      .pop        (pop),
      .head_job   (head_job)
   );

   // Emit the head job's units; pop on its last unit.
   cpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp        (rsp)
   );

endmodule

// ===== dv/tb_code_point_encoder_core.sv =====
`timescale 1ns / 1ps
// Testbench for code_point_encoder_core: checks every unit run against an in-bench predictor.
// Depends on cpe_pkg, cpe_channels and the encoder RTL; needs no files or arguments.
module tb_code_point_encoder_core;
   import cpe_pkg::*;

   // The format register is 2 bits wide; the top code has no encoding at all.
   localparam logic [1:0] FMT_UNDEF = 2'd3;

   localparam int CYCLE_LIMIT  = 200_000;
   localparam int IDLE_SETTLE  = 4;     // cycles after the last unit before a format write
   localparam int END_TAIL     = 10;
   localparam int HOLD_AT      = 150;   // units seen before the long rsp hold-off
   localparam int LONG_HOLD    = 80;

   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_UP_U   = 8'h55;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_UP_A   = 8'h41;

   // -------------------------------------------------------------------------
   // Expected-unit store with its own copy of the format register.
   // -------------------------------------------------------------------------
   class cpe_scoreboard;
      typedef struct {
         logic [15:0] unit;
         logic        last;
         logic        unrep;
      } unit_rec_type;

      logic [1:0]   fmt;
      unit_rec_type pending_units[$];
      int           mismatches;

      function new();
         fmt = FMT_UTF8;
         mismatches = 0;
      endfunction

      // Work out the run for one accepted code point and queue it.
      function void note_code(logic [31:0] cp);
         logic [15:0]  u [10];
         logic [31:0]  d;
         logic [7:0]   lead;
         logic [3:0]   nib;
         int           n;
         int           digits;
         int           k;
         unit_rec_type rec;
         n = 0;
         lead = 8'h00;
         case (fmt)
            FMT_UTF8: begin
               if (cp < 32'h80) begin
                  u[0] = cp[15:0];
                  n = 1;
               end else if (cp < 32'h8000_0000) begin
                  if (cp < 32'h800) begin
                     n = 2; lead = 8'hc0;
                  end else if (cp < 32'h1_0000) begin
                     n = 3; lead = 8'he0;
                  end else if (cp < 32'h20_0000) begin
                     n = 4; lead = 8'hf0;
                  end else if (cp < 32'h400_0000) begin
                     n = 5; lead = 8'hf8;
                  end else begin
                     n = 6; lead = 8'hfc;
                  end
                  for (k = 1; k < n; k++)
                     u[k] = 16'(((cp >> (6 * (n - 1 - k))) & 32'h3f) | 32'h80);
                  u[0] = 16'(((cp >> (6 * (n - 1))) | {24'h0, lead}) & 32'hff);
               end
            end
            FMT_UTF16: begin
               if (cp < 32'hd800 || (cp >= 32'he000 && cp <= 32'hffff)) begin
                  u[0] = cp[15:0];
                  n = 1;
               end else if (cp >= 32'h1_0000 && cp <= 32'h10_ffff) begin
                  d = cp - 32'h1_0000;
                  u[0] = 16'((d >> 10) + 32'hd800);
                  u[1] = 16'((d & 32'h3ff) + 32'hdc00);
                  n = 2;
               end
            end
            FMT_CESC: begin
               digits = (cp < 32'h1_0000) ? 4 : 8;
               u[0] = {8'h00, CH_BSLASH};
               u[1] = {8'h00, (digits == 4) ? CH_LOW_U : CH_UP_U};
               for (k = 0; k < digits; k++) begin
                  nib = 4'((cp >> (4 * (digits - 1 - k))) & 32'hf);
                  u[2 + k] = (nib < 4'd10) ? {8'h00, CH_ZERO + 8'(nib)}
                                           : {8'h00, CH_UP_A + 8'(nib) - 8'd10};
               end
               n = 2 + digits;
            end
            default: n = 0;
         endcase

         if (n == 0) begin
            rec.unit = 16'h0000; rec.last = 1'b1; rec.unrep = 1'b1;
            pending_units.push_back(rec);
         end else begin
            for (k = 0; k < n; k++) begin
               rec.unit = u[k]; rec.last = (k == n - 1); rec.unrep = 1'b0;
               pending_units.push_back(rec);
            end
         end
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      endtask

      // Compare one rsp transfer against the oldest expected unit.
      task check_unit(logic [15:0] unit, logic last, logic unrep);
         unit_rec_type want;
         if (pending_units.size() == 0) begin
            report_mismatch($sformatf("unexpected unit %h last %b unrep %b", unit, last, unrep));
            return;
         end
         want = pending_units.pop_front();
         if (unit !== want.unit)
            report_mismatch($sformatf("unit %h, want %h", unit, want.unit));
         if (last !== want.last)
            report_mismatch($sformatf("last %b, want %b (unit %h)", last, want.last, want.unit));
         if (unrep !== want.unrep)
            report_mismatch($sformatf("unrepresentable %b, want %b (unit %h)",
                                      unrep, want.unrep, want.unit));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, channels, DUT
   // -------------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_write_data;

   always #5 clock = ~clock;

   cpe_req_if req_if ();
   cpe_rsp_if rsp_if ();

   code_point_encoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_if.sink),
      .rsp              (rsp_if.source),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   cpe_scoreboard board = new();

   // Receiver pacing, shared between the rsp processes and the phase control.
   int steady     = 0;   // 1: no idling on either side for this phase
   int rsp_gap    = 0;
   int hold_left  = 0;
   int units_seen = 0;
   int cycle_count = 0;

   // Directed probes: the length boundaries of every encoding, the surrogate
   // range, the out-of-range values, hex digits 0-4, 8, 9 and A-F and the undefined format.
   typedef struct packed {
      logic [1:0]  fmt;
      logic [31:0] code;
   } probe_type;

   localparam int NUM_PROBES = 24;
   localparam probe_type PROBES [NUM_PROBES] = '{
      '{FMT_UTF8,  32'h0000_0000}, '{FMT_UTF8,  32'h0000_007f},
      '{FMT_UTF8,  32'h0000_0080}, '{FMT_UTF8,  32'h0000_07ff},
      '{FMT_UTF8,  32'h0000_0800}, '{FMT_UTF8,  32'h0000_ffff},
      '{FMT_UTF8,  32'h0001_0000}, '{FMT_UTF8,  32'h0020_0000},
      '{FMT_UTF8,  32'h0400_0000}, '{FMT_UTF8,  32'h7fff_ffff},
      '{FMT_UTF8,  32'h8000_0000},
      '{FMT_UTF16, 32'h0000_d7ff}, '{FMT_UTF16, 32'h0000_d800},
      '{FMT_UTF16, 32'h0000_dfff}, '{FMT_UTF16, 32'h0000_e000},
      '{FMT_UTF16, 32'h0001_0000}, '{FMT_UTF16, 32'h0010_ffff},
      '{FMT_UTF16, 32'h0011_0000},
      '{FMT_CESC,  32'h0000_1234}, '{FMT_CESC,  32'h0000_ffff},
      '{FMT_CESC,  32'h0001_0000}, '{FMT_CESC,  32'hfedc_ba98},
      '{FMT_UNDEF, 32'h0000_0041}, '{FMT_UNDEF, 32'hffff_ffff}
   };

   // Random phases: format and item count; two of them run without idling.
   localparam int NUM_PHASES = 7;
   localparam logic [1:0] PHASE_FMT [NUM_PHASES] =
      '{FMT_UTF8, FMT_UTF16, FMT_CESC, FMT_UNDEF, FMT_UTF8, FMT_UTF16, FMT_CESC};
   localparam int PHASE_ITEMS [NUM_PHASES] = '{60, 50, 40, 10, 50, 50, 40};

   // -------------------------------------------------------------------------
   // Stimulus helpers. All of them start and end at a falling edge.
   // -------------------------------------------------------------------------

   // Mostly values at or near a length/range boundary, some fully random.
   function automatic logic [31:0] pick_code();
      logic [31:0] edges [9] = '{32'h80, 32'h800, 32'h1_0000, 32'h20_0000, 32'h400_0000,
                                 32'h8000_0000, 32'hd800, 32'he000, 32'h11_0000};
      logic [31:0] b;
      b = edges[$urandom_range(0, 8)];
      if ($urandom_range(0, 9) < 3)
         return $urandom();
      case ($urandom_range(0, 3))
         0:       return b - 1;
         1:       return b;
         2:       return b + 1;
         default: return $urandom_range(0, b - 1);
      endcase
   endfunction

   // Offer one code point; valid stays high on return so back-to-back
   // transfers never lower and raise it in the same step.
   task automatic send_code(input logic [31:0] cp);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.code_point <= cp;
      do @(posedge clock); while (!req_if.ready);
      board.note_code(cp);
      @(negedge clock);
   endtask

   task automatic release_req();
      req_if.valid <= 1'b0;
   endtask

   // Idle: every expected unit delivered, then a settle wait for the pipe.
   task automatic wait_idle();
      while (board.pending_units.size() != 0) @(negedge clock);
      repeat (IDLE_SETTLE) @(negedge clock);
   endtask

   task automatic write_format(input logic [1:0] f);
      csr_write_enable <= 1'b1;
      csr_write_data   <= f;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.fmt = f;
   endtask

   // -------------------------------------------------------------------------
   // Receiver: ready changes at the falling edge, transfers are taken at the
   // rising edge. A one-time long hold-off lets the queue fill and stall req.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else if (!reset && rsp_if.valid && rsp_if.ready) begin
         board.check_unit(rsp_if.unit, rsp_if.last, rsp_if.unrepresentable);
         units_seen++;
         if (units_seen == HOLD_AT)
            hold_left = LONG_HOLD;
         rsp_gap = steady ? 0 : $urandom_range(0, 6);
      end
   end

   // -------------------------------------------------------------------------
   // Main sequence: reset, directed probes, random phases, drain, verdict.
   // -------------------------------------------------------------------------
   initial begin
      int i;
      int p;
      reset             = 1'b1;
      req_if.valid      = 1'b0;
      req_if.code_point = '0;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Format changes only between probes once the block has drained.
      for (i = 0; i < NUM_PROBES; i++) begin
         if (i == 0 || PROBES[i].fmt != PROBES[i - 1].fmt) begin
            release_req();
            wait_idle();
            write_format(PROBES[i].fmt);
         end
         send_code(PROBES[i].code);
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         release_req();
         wait_idle();
         steady = (p == 1 || p == 4);
         write_format(PHASE_FMT[p]);
         for (i = 0; i < PHASE_ITEMS[p]; i++)
            send_code(pick_code());
      end

      release_req();
      wait_idle();
      repeat (END_TAIL) @(negedge clock);
      if (board.mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
src/cpe_pkg.sv
src/cpe_channels.sv
src/cpe_front.sv
src/cpe_queue.sv
src/cpe_back.sv
src/code_point_encoder_core.sv
dv/tb_code_point_encoder_core.sv
